### sv/lpd_pkg.sv
package lpd_pkg;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      REG_PACKET_LIMIT = 1'b0,
      REG_BUFFER_LIMIT = 1'b1
   } reg_index_type;

   localparam logic [15:0] PACKET_LIMIT_RESET = 16'd1024;
   localparam logic [16:0] BUFFER_LIMIT_RESET = 17'd4096;

   // framing
   localparam logic [17:0] PREFIX_BYTES = 18'd2;

   // queue between parser and output side
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [15:0] packet_limit;
      logic [16:0] buffer_limit;
   } cfg_type;

   typedef struct packed {
      logic       last_of_frame;
      logic       first_of_frame;
      logic [7:0] payload_byte;
   } rsp_item_type;

endpackage

### sv/length_prefix_deframer.sv
// Length-prefix deframer.
// req_* carries received bytes, one per transaction. The parser looks for a
// 16-bit little-endian length prefix and forwards the payload bytes of each
// accepted frame on rsp_*, with tuser marking the first payload byte and
// tlast the final one. Prefix bytes, rejected lengths and oversized frames
// produce no output transaction.
// Throughput: one byte per cycle while the queue is not full; every byte is classified in the cycle it
// is accepted by the parser's counter/compare logic.
// Output path: an accepted payload byte is written into a small queue
// (QUEUE_DEPTH entries) between parser and output and leaves on rsp_* from the queue's head.
// When the receiver stalls, the queue fills and req_tready drops only once
// it is full; no byte is lost.
// Reset (synchronous, active high) empties the queue, returns the parser to
// prefix search and loads packet_limit = 1024, buffer_limit = 4096.
// csr_*: packet_limit at address 0, buffer_limit at address 4; write only
// while the block is idle.
module length_prefix_deframer
   import lpd_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // input byte stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   // payload stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] payload_byte
   output logic                  rsp_tuser,   // [0] first_of_frame
   output logic                  rsp_tlast,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg_ff, cfg_in;
   rsp_item_type parsed_item;
   rsp_item_type head_item;
   logic         parsed_push;
   logic         queue_full;
   logic         req_accept;
   logic         csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_PACKET_LIMIT: cfg_in.packet_limit = csr_pwdata[15:0];
            REG_BUFFER_LIMIT: cfg_in.buffer_limit = csr_pwdata[16:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_index)
         REG_PACKET_LIMIT: csr_prdata = {16'd0, cfg_ff.packet_limit};
         REG_BUFFER_LIMIT: csr_prdata = {15'd0, cfg_ff.buffer_limit};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_limit <= PACKET_LIMIT_RESET;
         cfg_ff.buffer_limit <= BUFFER_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify each byte
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   lpd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .in_byte  (req_tdata),
      .cfg      (cfg_ff),
      .push     (parsed_push),
      .item     (parsed_item)
   );

   // back: queue drives the payload stream
   lpd_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (parsed_push),
      .push_item (parsed_item),
      .full      (queue_full),
      .pop       (rsp_tready),
      .not_empty (rsp_tvalid),
      .head_item (head_item)
   );

   assign rsp_tdata = head_item.payload_byte;
   assign rsp_tuser = head_item.first_of_frame;
   assign rsp_tlast = head_item.last_of_frame;

endmodule

### sv/lpd_parser.sv
module lpd_parser
   import lpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [7:0]   in_byte,
   input  cfg_type      cfg,
   output logic         push,
   output rsp_item_type item
);

   typedef enum logic [1:0] {
      PH_EMPTY   = 2'd0,
      PH_HELD    = 2'd1,
      PH_FORWARD = 2'd2,
      PH_SWALLOW = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] remain_ff, remain_in;
   logic [16:0] count_ff, count_in;

   logic [17:0] count_sum;
   logic [17:0] limit_ext;
   logic [15:0] frame_len;
   logic [15:0] remain_dec;
   logic        overflow;

   assign count_sum  = {1'b0, count_ff} + 18'd1;
   assign limit_ext  = {1'b0, cfg.buffer_limit};
   assign overflow   = count_sum > limit_ext;
   assign frame_len  = {in_byte, held_ff};
   assign remain_dec = remain_ff - 16'd1;

   // next state per received byte; overflow check comes before parsing
   always_comb begin
      phase_in            = phase_ff;
      held_in             = held_ff;
      remain_in           = remain_ff;
      count_in            = count_ff;
      push                = 1'b0;
      item.payload_byte   = in_byte;
      item.first_of_frame = (count_sum == PREFIX_BYTES + 18'd1);
      item.last_of_frame  = (remain_dec == 16'd0);
      if (in_valid) begin
         count_in = count_sum[16:0];
         if (overflow) begin
            phase_in  = PH_EMPTY;
            held_in   = 8'd0;
            remain_in = 16'd0;
            count_in  = 17'd0;
         end else begin
            unique case (phase_ff)
               PH_EMPTY: begin
                  held_in  = in_byte;
                  phase_in = PH_HELD;
               end
               PH_HELD: begin
                  if (frame_len == 16'd0 || frame_len > cfg.packet_limit) begin
                     // rejected length: resync one byte later
                     held_in  = in_byte;
                     count_in = 17'd1;
                  end else begin
                     remain_in = frame_len;
                     if (PREFIX_BYTES + 18'(frame_len) > limit_ext) begin
                        phase_in = PH_SWALLOW;
                     end else begin
                        phase_in = PH_FORWARD;
                     end
                  end
               end
               PH_FORWARD: begin
                  push      = 1'b1;
                  remain_in = remain_dec;
                  if (remain_dec == 16'd0) begin
                     phase_in = PH_EMPTY;
                     held_in  = 8'd0;
                     count_in = 17'd0;
                  end
               end
               PH_SWALLOW: begin
                  remain_in = remain_dec;
                  if (remain_dec == 16'd0) begin
                     phase_in = PH_EMPTY;
                     held_in  = 8'd0;
                     count_in = 17'd0;
                  end
               end
               default: begin
                  phase_in = PH_EMPTY;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_EMPTY;
         held_ff   <= 8'd0;
         remain_ff <= 16'd0;
         count_ff  <= 17'd0;
      end else begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         remain_ff <= remain_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/lpd_queue.sv
module lpd_queue
   import lpd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output rsp_item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   rsp_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
